/* hw/rtl/rpts_pkg.sv */
// Shared types, codes and constants of the redundant packet transmit scheduler.
`default_nettype none
package rpts_pkg;

	localparam int TIME_W     = 32;
	localparam int CNT_W      = 32;
	localparam int CFG_W      = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int COPIES_W   = 2;
	localparam int IN_DATA_W  = 40;
	localparam int OUT_DATA_W = 168;

	// scheduler phases
	localparam logic [1:0] PH_IDLE  = 2'd0;
	localparam logic [1:0] PH_COPY1 = 2'd1;
	localparam logic [1:0] PH_GAP   = 2'd2;
	localparam logic [1:0] PH_COPY2 = 2'd3;

	// start codes
	localparam logic [1:0] START_NONE   = 2'd0;
	localparam logic [1:0] START_FIRST  = 2'd1;
	localparam logic [1:0] START_SECOND = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SEND_INTERVAL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_AIR       = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COPY_GAP      = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COPY_COUNT    = 2'd3;

	localparam logic [CFG_W-1:0]    RST_SEND_INTERVAL = 16'd100;
	localparam logic [CFG_W-1:0]    RST_MAX_AIR       = 16'd200;
	localparam logic [CFG_W-1:0]    RST_COPY_GAP      = 16'd20;
	localparam logic [COPIES_W-1:0] RST_COPY_COUNT    = 2'd2;

	// hard timeout at four times the max air time
	localparam int HARD_TIMEOUT_SHIFT = 2;
	localparam logic [COPIES_W-1:0] REPEAT_COPIES = 2'd2;

	typedef struct packed {
		logic        radio_accepts;
		logic        tx_done_event;
		logic        radio_present;
		logic [31:0] now_ms;
	} item_t;

	typedef struct packed {
		logic [COPIES_W-1:0] copy_count;
		logic [CFG_W-1:0]    copy_gap_ms;
		logic [CFG_W-1:0]    max_air_ms;
		logic [CFG_W-1:0]    send_interval_ms;
	} cfg_t;

	typedef struct packed {
		logic [1:0]       sched_state;
		logic [CNT_W-1:0] fallback_count;
		logic [CNT_W-1:0] timeout_count;
		logic [CNT_W-1:0] refused_count;
		logic [CNT_W-1:0] last_air_ms;
		logic             packet_finished;
		logic [CNT_W-1:0] packet_count;
		logic             build_request;
		logic [1:0]       start_copy;
	} result_t;

endpackage
`default_nettype wire

/* hw/rtl/rpts_in_reg.sv */
// Input register stage: captures one request per cycle and holds it under backpressure.
`default_nettype none
module rpts_in_reg
	import rpts_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [IN_DATA_W-1:0] in_data,
	output logic                      valid_s1,
	input  wire logic                 ready_s1,
	output item_t                     item_s1
);

	item_t item_d;

	assign item_d   = item_t'(in_data[$bits(item_t)-1:0]);
	assign in_ready = !valid_s1 || ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= item_d;
		end
	end

endmodule
`default_nettype wire

/* hw/rtl/rpts_core.sv */
// Scheduler state, single-pass step logic and result register.
`default_nettype none
module rpts_core
	import rpts_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire cfg_t  cfg,
	input  wire logic  valid_s1,
	output logic       ready_s1,
	input  wire item_t item_s1,
	output logic       valid_s2,
	input  wire logic  ready_s2,
	output result_t    result
);

	logic [1:0]        phase_q;
	logic              latch_q;
	logic [TIME_W-1:0] base_q;
	logic [TIME_W-1:0] copy_start_q;
	logic [TIME_W-1:0] gap_start_q;
	logic [CNT_W-1:0]  seq_q;
	logic [CNT_W-1:0]  air_q;
	logic [CNT_W-1:0]  refused_q;
	logic [CNT_W-1:0]  timeout_q;
	logic [CNT_W-1:0]  fallback_q;

	logic [1:0] start_s2;
	logic       build_s2;
	logic       finished_s2;

	logic [1:0]        phase_d;
	logic              latch_d;
	logic [TIME_W-1:0] base_d;
	logic [TIME_W-1:0] copy_start_d;
	logic [TIME_W-1:0] gap_start_d;
	logic [CNT_W-1:0]  seq_d;
	logic [CNT_W-1:0]  air_d;
	logic [CNT_W-1:0]  refused_d;
	logic [CNT_W-1:0]  timeout_d;
	logic [CNT_W-1:0]  fallback_d;
	logic [1:0]        start_d;
	logic              build_d;
	logic              finished_d;

	logic [TIME_W-1:0] now;
	logic              done;
	logic [TIME_W-1:0] air_elapsed;
	logic [TIME_W-1:0] send_elapsed;
	logic [TIME_W-1:0] send_behind;
	logic [TIME_W-1:0] gap_elapsed;
	logic [TIME_W-1:0] interval;
	logic [TIME_W-1:0] max_air;
	logic [TIME_W-1:0] hard_limit;
	logic              in_air;
	logic              hard_timeout;
	logic              air_fallback;
	logic              copy_done;
	logic              single_copy;
	logic              step;

	assign step     = valid_s1 && ready_s1;
	assign ready_s1 = !valid_s2 || ready_s2;

	assign now          = item_s1.now_ms;
	assign done         = latch_q || item_s1.tx_done_event;
	assign interval     = TIME_W'(cfg.send_interval_ms);
	assign max_air      = TIME_W'(cfg.max_air_ms);
	assign hard_limit   = TIME_W'({cfg.max_air_ms, HARD_TIMEOUT_SHIFT'(0)});
	assign air_elapsed  = now - copy_start_q;
	assign send_elapsed = now - base_q;
	assign send_behind  = send_elapsed - interval;
	assign gap_elapsed  = now - gap_start_q;
	assign in_air       = (phase_q == PH_COPY1) || (phase_q == PH_COPY2);
	assign hard_timeout = in_air && (air_elapsed > hard_limit);
	assign air_fallback = !done && (air_elapsed >= max_air);
	assign copy_done    = done || (air_elapsed >= max_air);
	assign single_copy  = cfg.copy_count < REPEAT_COPIES;

	always_comb begin
		phase_d      = phase_q;
		latch_d      = done;
		base_d       = base_q;
		copy_start_d = copy_start_q;
		gap_start_d  = gap_start_q;
		seq_d        = seq_q;
		air_d        = air_q;
		refused_d    = refused_q;
		timeout_d    = timeout_q;
		fallback_d   = fallback_q;
		start_d      = START_NONE;
		build_d      = 1'b0;
		finished_d   = 1'b0;
		if (item_s1.radio_present) begin
			if (hard_timeout) begin
				timeout_d = timeout_q + 1'b1;
				phase_d   = PH_IDLE;
			end else begin
				unique case (phase_q)
					PH_IDLE: begin
						if (send_elapsed >= interval) begin
							base_d  = (send_behind >= interval) ? now : base_q + interval;
							seq_d   = seq_q + 1'b1;
							build_d = 1'b1;
							if (item_s1.radio_accepts) begin
								latch_d      = 1'b0;
								copy_start_d = now;
								phase_d      = PH_COPY1;
								start_d      = START_FIRST;
							end else begin
								refused_d = refused_q + 1'b1;
							end
						end
					end
					PH_COPY1: begin
						if (copy_done) begin
							if (air_fallback) begin
								fallback_d = fallback_q + 1'b1;
							end
							air_d = air_elapsed;
							if (single_copy) begin
								phase_d    = PH_IDLE;
								finished_d = 1'b1;
							end else begin
								gap_start_d = now;
								phase_d     = PH_GAP;
							end
						end
					end
					PH_GAP: begin
						if (gap_elapsed >= TIME_W'(cfg.copy_gap_ms)) begin
							if (item_s1.radio_accepts) begin
								latch_d      = 1'b0;
								copy_start_d = now;
								phase_d      = PH_COPY2;
								start_d      = START_SECOND;
							end else begin
								refused_d = refused_q + 1'b1;
								phase_d   = PH_IDLE;
							end
						end
					end
					PH_COPY2: begin
						if (copy_done) begin
							if (air_fallback) begin
								fallback_d = fallback_q + 1'b1;
							end
							phase_d    = PH_IDLE;
							finished_d = 1'b1;
						end
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			latch_q      <= 1'b0;
			base_q       <= '0;
			copy_start_q <= '0;
			gap_start_q  <= '0;
			seq_q        <= '0;
			air_q        <= '0;
			refused_q    <= '0;
			timeout_q    <= '0;
			fallback_q   <= '0;
			valid_s2     <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s2 <= valid_s1;
			end
			if (step) begin
				phase_q      <= phase_d;
				latch_q      <= latch_d;
				base_q       <= base_d;
				copy_start_q <= copy_start_d;
				gap_start_q  <= gap_start_d;
				seq_q        <= seq_d;
				air_q        <= air_d;
				refused_q    <= refused_d;
				timeout_q    <= timeout_d;
				fallback_q   <= fallback_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			start_s2    <= start_d;
			build_s2    <= build_d;
			finished_s2 <= finished_d;
		end
	end

	// counters only move with a step, so they match the held result
	always_comb begin
		result.start_copy      = start_s2;
		result.build_request   = build_s2;
		result.packet_count    = seq_q;
		result.packet_finished = finished_s2;
		result.last_air_ms     = air_q;
		result.refused_count   = refused_q;
		result.timeout_count   = timeout_q;
		result.fallback_count  = fallback_q;
		result.sched_state     = phase_q;
	end

endmodule
`default_nettype wire

/* hw/rtl/redundant_packet_tx_scheduler.sv */
// A request is held in the input register, and its step result is registered in the
// core. Throughput: one request per cycle while m_tready takes each result; the step
// logic is a single compare/add pass.
// While a result waits, one more request can enter and is held in the input register.
// Reset (arst_n low, asynchronous): phase idle, all counters and times zero,
// registers back to interval 100, max air 200, gap 20, two copies.
`default_nettype none
module redundant_packet_tx_scheduler
	import rpts_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_W-1:0]      cfg_data,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	// now_ms[31:0], radio_present[32], tx_done_event[33], radio_accepts[34], zero fill
	input  wire logic [IN_DATA_W-1:0]  s_tdata,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	// start_copy[1:0], build_request[2], packet_count[34:3], packet_finished[35],
	// last_air_ms[67:36], refused_count[99:68], timeout_count[131:100],
	// fallback_count[163:132], sched_state[165:164], zero fill
	output logic [OUT_DATA_W-1:0]      m_tdata
);

	cfg_t    cfg_q;
	item_t   item_s1;
	logic    valid_s1;
	logic    ready_s1;
	result_t result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.send_interval_ms <= RST_SEND_INTERVAL;
			cfg_q.max_air_ms       <= RST_MAX_AIR;
			cfg_q.copy_gap_ms      <= RST_COPY_GAP;
			cfg_q.copy_count       <= RST_COPY_COUNT;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_SEND_INTERVAL: cfg_q.send_interval_ms <= cfg_data;
				REG_MAX_AIR:       cfg_q.max_air_ms       <= cfg_data;
				REG_COPY_GAP:      cfg_q.copy_gap_ms      <= cfg_data;
				REG_COPY_COUNT:    cfg_q.copy_count       <= cfg_data[COPIES_W-1:0];
			endcase
		end
	end

	rpts_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_data  (s_tdata),
		.valid_s1 (valid_s1),
		.ready_s1 (ready_s1),
		.item_s1  (item_s1)
	);

	rpts_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.valid_s1 (valid_s1),
		.ready_s1 (ready_s1),
		.item_s1  (item_s1),
		.valid_s2 (m_tvalid),
		.ready_s2 (m_tready),
		.result   (result)
	);

	assign m_tdata = {(OUT_DATA_W - $bits(result_t))'(0), result};

endmodule
`default_nettype wire

/* hw/rtl/rpts_checker.sv */
// Port-level checks of the scheduler results, bound to the top level.
`default_nettype none
module rpts_checker
	import rpts_pkg::*;
(
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  m_tvalid,
	input wire logic                  m_tready,
	input wire logic [OUT_DATA_W-1:0] m_tdata
);

	logic [1:0] start_copy;
	logic [1:0] sched_state;
	logic       build_request;
	logic       packet_finished;

	assign start_copy      = m_tdata[1:0];
	assign build_request   = m_tdata[2];
	assign packet_finished = m_tdata[35];
	assign sched_state     = m_tdata[165:164];

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_first_start: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && start_copy == START_FIRST |-> sched_state == PH_COPY1 && build_request)
		else $error("first copy start without copy phase or build");

	a_second_start: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && start_copy == START_SECOND |-> sched_state == PH_COPY2 && !build_request)
		else $error("second copy start in wrong phase");

	a_finish_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && packet_finished |-> sched_state == PH_IDLE && start_copy == START_NONE)
		else $error("finished packet not idle");

	a_build_phase: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && build_request |-> sched_state == PH_IDLE || sched_state == PH_COPY1)
		else $error("build request outside idle step");

endmodule

bind redundant_packet_tx_scheduler rpts_checker u_rpts_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
`default_nettype wire
